@@ hdl/fpmt_pkg.sv @@
// ----------------------------------------------------------------------------
// fpmt_pkg
// Shared types, multiply-accumulate control and sine table generation for the
// fixed-point matrix transform engine.
// ----------------------------------------------------------------------------
package fpmt_pkg;

  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  typedef enum logic [1:0] {
    MAC_FIRST,
    MAC_FIRST_NEG,
    MAC_ADD,
    MAC_SUB
  } mac_op_e;

  typedef enum logic {
    WB_SHIFT,
    WB_SET
  } wb_mode_e;

  typedef struct packed {
    logic       valid;
    mac_op_e    op;
    logic       last;
    logic [3:0] dest;
    wb_mode_e   mode;
  } mac_ctl_t;

  typedef struct packed {
    logic        valid;
    logic [3:0]  dest;
    wb_mode_e    mode;
    logic [31:0] value;
  } mac_res_t;

  function automatic logic [63:0] sq_step(logic [63:0] term, logic [63:0] x);
    logic [63:0] t;
    t = (term * x) >> 30;
    return (t * x) >> 30;
  endfunction

  // Taylor series of sin over a quarter circle, Q30, rounded to fb fraction bits
  function automatic logic [31:0] quarter_sine(int q, int fb, int tb);
    logic [63:0] quarter;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    quarter = 64'd1 << (tb - 2);
    if (q == 0) return 32'd0;
    if (64'(q) >= quarter) return 32'd1 << fb;
    x    = (HalfPiQ30 * 64'(q) + (quarter >> 1)) >> (tb - 2);
    term = x;
    sum  = x;
    term = sq_step(term, x) / 64'd6;   sum = sum - term;
    term = sq_step(term, x) / 64'd20;  sum = sum + term;
    term = sq_step(term, x) / 64'd42;  sum = sum - term;
    term = sq_step(term, x) / 64'd72;  sum = sum + term;
    term = sq_step(term, x) / 64'd110; sum = sum - term;
    term = sq_step(term, x) / 64'd156; sum = sum + term;
    term = sq_step(term, x) / 64'd210; sum = sum - term;
    term = sq_step(term, x) / 64'd272; sum = sum + term;
    term = sq_step(term, x) / 64'd342; sum = sum - term;
    return 32'(((sum << fb) + (64'd1 << 29)) >> 30);
  endfunction

endpackage

@@ hdl/fpmt_sine.sv @@
// ----------------------------------------------------------------------------
// fpmt_sine
// Quarter-wave sine ROM with registered output; optional negation of result.
// ----------------------------------------------------------------------------
module fpmt_sine import fpmt_pkg::*; #(
  parameter int FRACTION_BITS   = 14,
  parameter int SINE_TABLE_BITS = 12
) (
  input  logic        clk_i,
  input  logic [15:0] angle_i,
  input  logic        neg_i,
  output logic [31:0] value_o
);

  localparam int QuarterBits = SINE_TABLE_BITS - 2;
  localparam int Quarter     = 1 << QuarterBits;
  localparam int TabW        = FRACTION_BITS + 1;
  localparam int AddrW       = QuarterBits + 1;

  logic [TabW-1:0]            tab [Quarter+1];
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [1:0]                 quad;
  logic [QuarterBits-1:0]     rem;
  logic [AddrW-1:0]           addr;
  logic [TabW-1:0]            data_q;
  logic                       neg_q;
  logic [31:0]                ext;

  for (genvar i = 0; i <= Quarter; i++) begin : g_tab
    assign tab[i] = TabW'(quarter_sine(i, FRACTION_BITS, SINE_TABLE_BITS));
  end

  assign idx  = angle_i[15 -: SINE_TABLE_BITS];
  assign quad = idx[SINE_TABLE_BITS-1 -: 2];
  assign rem  = idx[QuarterBits-1:0];
  assign addr = quad[0] ? AddrW'(Quarter) - {1'b0, rem} : {1'b0, rem};

  always_ff @(posedge clk_i) begin
    data_q <= tab[addr];
    neg_q  <= quad[1] ^ neg_i;
  end

  assign ext     = 32'(data_q);
  assign value_o = neg_q ? 32'd0 - ext : ext;

endmodule

@@ hdl/fpmt_mac.sv @@
// ----------------------------------------------------------------------------
// fpmt_mac
// Shared 32x32 wrapping multiplier with registered product and accumulator.
// ----------------------------------------------------------------------------
module fpmt_mac import fpmt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mac_ctl_t    ctl_i,
  input  logic [31:0] op_a_i,
  input  logic [31:0] op_b_i,
  output mac_res_t    res_o
);

  mac_ctl_t    ctl_q;
  logic [31:0] prod_q;
  logic [31:0] acc_q;
  logic [31:0] acc_d;
  logic        res_valid_q;
  logic [3:0]  res_dest_q;
  wb_mode_e    res_mode_q;

  always_ff @(posedge clk_i) begin
    prod_q <= op_a_i * op_b_i;
  end

  always_comb begin
    unique case (ctl_q.op)
      MAC_FIRST:     acc_d = prod_q;
      MAC_FIRST_NEG: acc_d = 32'd0 - prod_q;
      MAC_ADD:       acc_d = acc_q + prod_q;
      MAC_SUB:       acc_d = acc_q - prod_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      ctl_q       <= ctl_i;
      res_valid_q <= ctl_q.valid & ctl_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_q.valid) begin
      acc_q <= acc_d;
    end
    res_dest_q <= ctl_q.dest;
    res_mode_q <= ctl_q.mode;
  end

  assign res_o = '{valid: res_valid_q, dest: res_dest_q, mode: res_mode_q, value: acc_q};

endmodule

@@ hdl/fixed_point_matrix_transform_engine.sv @@
// ----------------------------------------------------------------------------
// fixed_point_matrix_transform_engine
// 3x4 fixed-point transform matrix with rotate, translate and entry access.
// ----------------------------------------------------------------------------
// One word is taken at a time; s_axis_tready is high only while the engine is
// idle, and the result word sits in an output register so a new word can be
// taken while it waits. All products go through one 32x32 multiply-accumulate
// unit, one product per cycle; a rotation does table lookups plus twelve
// products per non-zero axis, and a write, read or unused command goes
// straight to the finish step, where the result is loaded.
module fixed_point_matrix_transform_engine import fpmt_pkg::*; #(
  parameter int FRACTION_BITS   = 14,
  parameter int SINE_TABLE_BITS = 12
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // angle_y, angle_x, angle_z, packed_angles, vec_x, vec_y, vec_z,
  // entry_index, entry_value, zero pad
  input  logic [215:0] s_axis_tdata,
  // command
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // read_value
  output logic [31:0]  m_axis_tdata,
  // within_far
  output logic [0:0]   m_axis_tuser
);

  localparam int NumEntries = 12;

  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_ROT_YXZ,
    CMD_ROT_PACKED,
    CMD_TRANS_REL,
    CMD_TRANS_ABS
  } cmd_e;

  typedef enum logic [1:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_ORIGIN_Z,
    REG_FAR_LIMIT
  } cfg_reg_e;

  typedef enum logic [1:0] {
    AX_Y,
    AX_X,
    AX_Z
  } axis_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PICK,
    ST_ANG_S,
    ST_ANG_C,
    ST_ANG_W,
    ST_MUL,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // input word fields
  logic [15:0] in_ay, in_ax, in_az;
  logic [29:0] in_pk;
  logic [31:0] in_vx, in_vy, in_vz, in_val;
  logic [3:0]  in_idx;
  logic [2:0]  in_cmd;
  logic        in_rot, in_packed, in_abs;
  logic [15:0] sel_ay, sel_ax, sel_az;
  logic        accept;

  // configuration
  logic [31:0] org_x_q, org_y_q, org_z_q;
  logic [30:0] far_q;

  // latched item
  logic [2:0]  cmd_q;
  logic [15:0] ay_q, ax_q, az_q;
  logic [31:0] vx_q, vy_q, vz_q, val_q;
  logic [3:0]  idx_q;

  // sequencer
  state_e      state_q;
  axis_e       axis_q;
  logic [2:0]  pend_q;
  logic [1:0]  row_q, k_q, k_last;
  logic        drain_q;
  logic        is_rot, is_rel, fin_go;

  // matrix and datapath
  logic [31:0] ent_q [NumEntries];
  logic [31:0] s_q, c_q;
  logic [1:0]  col, ca, cb;
  logic [3:0]  rd_addr;
  logic [31:0] rd_data;
  logic [31:0] op_b;
  mac_ctl_t    mac_ctl;
  mac_res_t    mac_res;
  logic [31:0] wb_value;
  logic [15:0] cur_ang, rom_ang;
  logic [31:0] rom_val;
  logic [31:0] mag3, mag7, mag11;
  logic        far_ok;

  // output register
  logic        m_tvalid_q;
  logic [31:0] rd_q;
  logic        wf_q;

  assign in_ay  = s_axis_tdata[15:0];
  assign in_ax  = s_axis_tdata[31:16];
  assign in_az  = s_axis_tdata[47:32];
  assign in_pk  = s_axis_tdata[77:48];
  assign in_vx  = s_axis_tdata[109:78];
  assign in_vy  = s_axis_tdata[141:110];
  assign in_vz  = s_axis_tdata[173:142];
  assign in_idx = s_axis_tdata[177:174];
  assign in_val = s_axis_tdata[209:178];
  assign in_cmd = s_axis_tuser;

  assign in_packed = (in_cmd == CMD_ROT_PACKED);
  assign in_rot    = (in_cmd == CMD_ROT_YXZ) || in_packed;
  assign in_abs    = (in_cmd == CMD_TRANS_ABS);
  assign sel_ay    = in_packed ? {in_pk[19:10], 6'd0} : in_ay;
  assign sel_ax    = in_packed ? {in_pk[29:20], 6'd0} : in_ax;
  assign sel_az    = in_packed ? {in_pk[9:0], 6'd0}   : in_az;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      org_z_q <= '0;
      far_q   <= '1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ORIGIN_X:  org_x_q <= cfg_data_i;
        REG_ORIGIN_Y:  org_y_q <= cfg_data_i;
        REG_ORIGIN_Z:  org_z_q <= cfg_data_i;
        REG_FAR_LIMIT: far_q   <= cfg_data_i[30:0];
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= in_cmd;
      ay_q  <= sel_ay;
      ax_q  <= sel_ax;
      az_q  <= sel_az;
      vx_q  <= in_abs ? in_vx - org_x_q : in_vx;
      vy_q  <= in_abs ? in_vy - org_y_q : in_vy;
      vz_q  <= in_abs ? in_vz - org_z_q : in_vz;
      idx_q <= in_idx;
      val_q <= in_val;
    end
    if (state_q == ST_ANG_C) s_q <= rom_val;
    if (state_q == ST_ANG_W) c_q <= rom_val;
  end

  assign is_rot = (cmd_q == CMD_ROT_YXZ) || (cmd_q == CMD_ROT_PACKED);
  assign is_rel = (cmd_q == CMD_TRANS_REL);
  assign k_last = (is_rot || is_rel) ? 2'd3 : 2'd2;
  assign fin_go = !m_tvalid_q || m_axis_tready;

  // rotation angle and column pair of the current axis
  always_comb begin
    unique case (axis_q)
      AX_Y: begin
        cur_ang = ay_q;
        ca      = 2'd0;
        cb      = 2'd2;
      end
      AX_X: begin
        cur_ang = ax_q;
        ca      = 2'd1;
        cb      = 2'd2;
      end
      AX_Z: begin
        cur_ang = az_q;
        ca      = 2'd0;
        cb      = 2'd1;
      end
      default: begin
        cur_ang = ay_q;
        ca      = 2'd0;
        cb      = 2'd2;
      end
    endcase
  end

  assign rom_ang = (state_q == ST_ANG_C) ? cur_ang + 16'h4000 : cur_ang;

  fpmt_sine #(
    .FRACTION_BITS  (FRACTION_BITS),
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_sine (
    .clk_i  (clk_i),
    .angle_i(rom_ang),
    .neg_i  ((state_q == ST_ANG_S) && (axis_q == AX_Y)),
    .value_o(rom_val)
  );

  // product schedule: rotation a'=a*c+b*s, b'=b*c-a*s; translation row dot
  always_comb begin
    mac_ctl       = '0;
    mac_ctl.valid = (state_q == ST_MUL);
    mac_ctl.mode  = is_rot ? WB_SHIFT : WB_SET;
    col           = 2'd0;
    op_b          = vx_q;
    if (is_rot) begin
      unique case (k_q)
        2'd0: begin
          col        = ca;
          op_b       = c_q;
          mac_ctl.op = MAC_FIRST;
        end
        2'd1: begin
          col          = cb;
          op_b         = s_q;
          mac_ctl.op   = MAC_ADD;
          mac_ctl.last = 1'b1;
          mac_ctl.dest = {row_q, ca};
        end
        2'd2: begin
          col        = ca;
          op_b       = s_q;
          mac_ctl.op = MAC_FIRST_NEG;
        end
        2'd3: begin
          col          = cb;
          op_b         = c_q;
          mac_ctl.op   = MAC_ADD;
          mac_ctl.last = 1'b1;
          mac_ctl.dest = {row_q, cb};
        end
      endcase
    end else begin
      mac_ctl.dest = {row_q, 2'd3};
      mac_ctl.last = (k_q == k_last);
      unique case (k_q)
        2'd0: begin
          col        = 2'd0;
          op_b       = vx_q;
          mac_ctl.op = MAC_FIRST;
        end
        2'd1: begin
          col        = 2'd1;
          op_b       = vy_q;
          mac_ctl.op = MAC_ADD;
        end
        2'd2: begin
          col        = 2'd2;
          op_b       = vz_q;
          mac_ctl.op = MAC_ADD;
        end
        2'd3: begin
          // relative: add the old translation entry
          col        = 2'd3;
          op_b       = 32'd1;
          mac_ctl.op = MAC_ADD;
        end
      endcase
    end
  end

  assign rd_addr = (state_q == ST_FINISH) ? idx_q : {row_q, col};
  assign rd_data = (rd_addr < 4'(NumEntries)) ? ent_q[rd_addr] : 32'd0;

  fpmt_mac u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (mac_ctl),
    .op_a_i(rd_data),
    .op_b_i(op_b),
    .res_o (mac_res)
  );

  assign wb_value = (mac_res.mode == WB_SHIFT) ?
                    32'($signed(mac_res.value) >>> FRACTION_BITS) : mac_res.value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumEntries; i++) begin
        ent_q[i] <= (i == 0 || i == 5 || i == 10) ? 32'd1 << FRACTION_BITS : 32'd0;
      end
    end else if (mac_res.valid) begin
      ent_q[mac_res.dest] <= wb_value;
    end else if ((state_q == ST_FINISH) && fin_go && (cmd_q == CMD_WRITE) &&
                 (idx_q < 4'(NumEntries))) begin
      ent_q[idx_q] <= val_q;
    end
  end

  assign mag3   = ent_q[3][31]  ? 32'd0 - ent_q[3]  : ent_q[3];
  assign mag7   = ent_q[7][31]  ? 32'd0 - ent_q[7]  : ent_q[7];
  assign mag11  = ent_q[11][31] ? 32'd0 - ent_q[11] : ent_q[11];
  assign far_ok = (mag3 <= {1'b0, far_q}) && (mag7 <= {1'b0, far_q}) &&
                  (mag11 <= {1'b0, far_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      axis_q     <= AX_Y;
      pend_q     <= '0;
      row_q      <= '0;
      k_q        <= '0;
      drain_q    <= 1'b0;
      m_tvalid_q <= 1'b0;
      rd_q       <= '0;
      wf_q       <= 1'b0;
    end else begin
      if ((state_q == ST_FINISH) && fin_go) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            row_q  <= '0;
            k_q    <= '0;
            pend_q <= in_rot ? {sel_az != 16'd0, sel_ax != 16'd0, sel_ay != 16'd0} : 3'd0;
            if (in_rot) begin
              state_q <= ST_PICK;
            end else if ((in_cmd == CMD_TRANS_REL) || in_abs) begin
              state_q <= ST_MUL;
            end else begin
              state_q <= ST_FINISH;
            end
          end
        end
        ST_PICK: begin
          priority if (pend_q[0]) begin
            axis_q    <= AX_Y;
            pend_q[0] <= 1'b0;
            state_q   <= ST_ANG_S;
          end else if (pend_q[1]) begin
            axis_q    <= AX_X;
            pend_q[1] <= 1'b0;
            state_q   <= ST_ANG_S;
          end else if (pend_q[2]) begin
            axis_q    <= AX_Z;
            pend_q[2] <= 1'b0;
            state_q   <= ST_ANG_S;
          end else begin
            drain_q <= 1'b0;
            state_q <= ST_DRAIN;
          end
        end
        ST_ANG_S: state_q <= ST_ANG_C;
        ST_ANG_C: state_q <= ST_ANG_W;
        ST_ANG_W: begin
          row_q   <= '0;
          k_q     <= '0;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          if (k_q == k_last) begin
            k_q <= '0;
            if (row_q == 2'd2) begin
              row_q   <= '0;
              drain_q <= 1'b0;
              state_q <= is_rot ? ST_PICK : ST_DRAIN;
            end else begin
              row_q <= row_q + 2'd1;
            end
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
        ST_DRAIN: begin
          drain_q <= 1'b1;
          if (drain_q) state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (fin_go) begin
            rd_q    <= (cmd_q == CMD_READ) ? rd_data : 32'd0;
            wf_q    <= is_rel && far_ok;
            state_q <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign m_axis_tvalid   = m_tvalid_q;
  assign m_axis_tdata    = rd_q;
  assign m_axis_tuser[0] = wf_q;

  a_result_from_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == ST_FINISH)
    else $error("result word appeared outside the finish step");

  a_no_writeback_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_FINISH) |-> !mac_res.valid)
    else $error("multiplier write-back after the sequence ended");

  a_row_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> row_q != 2'd3)
    else $error("matrix row counter out of range");

endmodule

@@ tb/fixed_point_matrix_transform_engine_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_matrix_transform_engine_tb
// Drives entry writes and reads, rotations, packed rotations and relative and
// absolute translations into the engine over several register settings. A
// scoreboard keeps its own copy of the matrix and registers, predicts each
// result word and checks the returned words in order. Both stream sides idle
// at random, with one quiet phase, one long output hold-off and one full
// drain in the middle of a phase.
// ----------------------------------------------------------------------------
module fixed_point_matrix_transform_engine_tb;

  localparam int FRAC_BITS    = 14;
  localparam int LUT_BITS     = 12;
  localparam int QUARTER      = 1 << (LUT_BITS - 2);
  localparam logic [15:0] QUARTER_TURN = 16'h4000;
  localparam logic [31:0] UNIT = 32'd1 << FRAC_BITS;
  localparam int PHASE_WORDS  = 206;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT  = 5000;

  typedef enum logic [2:0] {
    CMD_WRITE_ENTRY,
    CMD_READ_ENTRY,
    CMD_ROTATE_YXZ,
    CMD_ROTATE_PACKED,
    CMD_TRANSLATE_REL,
    CMD_TRANSLATE_ABS,
    CMD_UNUSED_6,
    CMD_UNUSED_7
  } xform_cmd_e;

  typedef enum logic [1:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_ORIGIN_Z,
    REG_FAR_LIMIT
  } xform_reg_e;

  typedef struct packed {
    logic [31:0] entry_value;
    logic [3:0]  entry_index;
    logic [31:0] vec_z;
    logic [31:0] vec_y;
    logic [31:0] vec_x;
    logic [29:0] packed_angles;
    logic [15:0] angle_z;
    logic [15:0] angle_x;
    logic [15:0] angle_y;
  } xform_fields_t;

  class xform_scoreboard;
    logic [31:0] mat [12];
    logic [31:0] origin [3];
    logic [30:0] far_lim;
    logic [31:0] quarter_lut [0:QUARTER];
    logic [31:0] exp_read [$];
    logic        exp_within [$];
    int          errors;

    function new();
      for (int q = 0; q <= QUARTER; q++) quarter_lut[q] = calc_quarter_sine(q);
      for (int i = 0; i < 12; i++) mat[i] = 32'd0;
      mat[0]  = UNIT;
      mat[5]  = UNIT;
      mat[10] = UNIT;
      origin[0] = 32'd0;
      origin[1] = 32'd0;
      origin[2] = 32'd0;
      far_lim   = '1;
      errors    = 0;
    endfunction

    // Taylor series in Q30 over a quarter circle, rounded to the fraction
    function logic [31:0] calc_quarter_sine(int q);
      logic [63:0] x;
      logic [63:0] term;
      logic [63:0] sum;
      if (q == 0) return 32'd0;
      if (q >= QUARTER) return UNIT;
      x = (64'd1686629713 * 64'(q) + 64'(QUARTER / 2)) / 64'(QUARTER);
      term = x;
      sum  = x;
      for (int n = 1; n <= 9; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / (64'(2 * n) * 64'(2 * n + 1));
        if (n % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      return 32'((sum * 64'(UNIT) + (64'd1 << 29)) >> 30);
    endfunction

    function logic [31:0] sine(logic [15:0] ang);
      int idx;
      int r;
      logic [31:0] v;
      idx = int'(ang) >> (16 - LUT_BITS);
      r   = idx % QUARTER;
      v   = ((idx / QUARTER) % 2 == 1) ? quarter_lut[QUARTER - r] : quarter_lut[r];
      return (idx / (2 * QUARTER) == 1) ? -v : v;
    endfunction

    function logic [31:0] shift_frac(logic [31:0] v);
      return $signed(v) >>> FRAC_BITS;
    endfunction

    function void rotate_pair(int ca, int cb, logic [31:0] s, logic [31:0] c);
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] r0;
      logic [31:0] r1;
      for (int row = 0; row < 3; row++) begin
        a  = mat[4 * row + ca];
        b  = mat[4 * row + cb];
        r0 = a * c + b * s;
        r1 = b * c - a * s;
        mat[4 * row + ca] = shift_frac(r0);
        mat[4 * row + cb] = shift_frac(r1);
      end
    endfunction

    function void rotate_yxz(logic [15:0] ay, logic [15:0] ax, logic [15:0] az);
      if (ay != 0) rotate_pair(0, 2, -sine(ay), sine(ay + QUARTER_TURN));
      if (ax != 0) rotate_pair(1, 2, sine(ax), sine(ax + QUARTER_TURN));
      if (az != 0) rotate_pair(0, 1, sine(az), sine(az + QUARTER_TURN));
    endfunction

    function logic [31:0] row_dot(int r, logic [31:0] x, logic [31:0] y, logic [31:0] z);
      return mat[4 * r] * x + mat[4 * r + 1] * y + mat[4 * r + 2] * z;
    endfunction

    function logic in_far(logic [31:0] v);
      logic [31:0] m;
      m = v[31] ? -v : v;
      return m <= {1'b0, far_lim};
    endfunction

    function void write_reg(xform_reg_e idx, logic [31:0] val);
      case (idx)
        REG_ORIGIN_X: origin[0] = val;
        REG_ORIGIN_Y: origin[1] = val;
        REG_ORIGIN_Z: origin[2] = val;
        default:      far_lim = val[30:0];
      endcase
    endfunction

    function void note_word(xform_cmd_e cmd, xform_fields_t f);
      logic [31:0] rd;
      logic        wf;
      logic [31:0] vx;
      logic [31:0] vy;
      logic [31:0] vz;
      logic [29:0] p;
      rd = 32'd0;
      wf = 1'b0;
      p  = f.packed_angles;
      case (cmd)
        CMD_WRITE_ENTRY: begin
          if (f.entry_index < 12) mat[f.entry_index] = f.entry_value;
        end
        CMD_READ_ENTRY: begin
          if (f.entry_index < 12) rd = mat[f.entry_index];
        end
        CMD_ROTATE_YXZ: rotate_yxz(f.angle_y, f.angle_x, f.angle_z);
        CMD_ROTATE_PACKED: begin
          rotate_yxz({p[19:10], 6'd0}, {p[29:20], 6'd0}, {p[9:0], 6'd0});
        end
        CMD_TRANSLATE_REL: begin
          for (int r = 0; r < 3; r++)
            mat[4 * r + 3] = mat[4 * r + 3] + row_dot(r, f.vec_x, f.vec_y, f.vec_z);
          wf = in_far(mat[3]) && in_far(mat[7]) && in_far(mat[11]);
        end
        CMD_TRANSLATE_ABS: begin
          vx = f.vec_x - origin[0];
          vy = f.vec_y - origin[1];
          vz = f.vec_z - origin[2];
          for (int r = 0; r < 3; r++) mat[4 * r + 3] = row_dot(r, vx, vy, vz);
        end
        default: ;
      endcase
      exp_read.push_back(rd);
      exp_within.push_back(wf);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%t mismatch: %s", $time, msg);
    endfunction

    function void check_word(logic [31:0] rd, logic wf);
      logic [31:0] e_rd;
      logic        e_wf;
      if (exp_read.size() == 0) begin
        flag($sformatf("unexpected word read_value=%h within_far=%b", rd, wf));
        return;
      end
      e_rd = exp_read.pop_front();
      e_wf = exp_within.pop_front();
      if (rd !== e_rd) flag($sformatf("read_value expected %h actual %h", e_rd, rd));
      if (wf !== e_wf) flag($sformatf("within_far expected %b actual %b", e_wf, wf));
    endfunction

    function int pending();
      return exp_read.size();
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i;
  logic [31:0]  cfg_data_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [215:0] s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [31:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  xform_scoreboard sb;
  bit no_idle;
  bit hold_request;
  int words_sent;

  fixed_point_matrix_transform_engine uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] small_signed(int span);
    return 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return small_signed(1 << 15);
      2: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'd0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return small_signed(1 << 20);
    endcase
  endfunction

  function automatic xform_fields_t random_fields();
    xform_fields_t f;
    f.angle_y       = 16'($urandom);
    f.angle_x       = 16'($urandom);
    f.angle_z       = 16'($urandom);
    f.packed_angles = 30'($urandom);
    f.vec_x         = pick_value();
    f.vec_y         = pick_value();
    f.vec_z         = pick_value();
    f.entry_index   = 4'($urandom_range(0, 15));
    f.entry_value   = pick_value();
    return f;
  endfunction

  function automatic logic [15:0] rand_angle();
    return ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
  endfunction

  task automatic send_word(xform_cmd_e cmd, xform_fields_t f);
    if (!no_idle && $urandom_range(0, 99) < 13) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, f};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(cmd, f);
    words_sent++;
  endtask

  task automatic do_write(int idx, logic [31:0] val);
    xform_fields_t f;
    f = random_fields();
    f.entry_index = 4'(idx);
    f.entry_value = val;
    send_word(CMD_WRITE_ENTRY, f);
  endtask

  task automatic do_read(int idx);
    xform_fields_t f;
    f = random_fields();
    f.entry_index = 4'(idx);
    send_word(CMD_READ_ENTRY, f);
  endtask

  task automatic do_rotate(logic [15:0] ay, logic [15:0] ax, logic [15:0] az);
    xform_fields_t f;
    f = random_fields();
    f.angle_y = ay;
    f.angle_x = ax;
    f.angle_z = az;
    send_word(CMD_ROTATE_YXZ, f);
  endtask

  task automatic do_rotate_packed(logic [29:0] p);
    xform_fields_t f;
    f = random_fields();
    f.packed_angles = p;
    send_word(CMD_ROTATE_PACKED, f);
  endtask

  task automatic do_move(xform_cmd_e cmd, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    xform_fields_t f;
    f = random_fields();
    f.vec_x = x;
    f.vec_y = y;
    f.vec_z = z;
    send_word(cmd, f);
  endtask

  task automatic set_regs(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                          logic [31:0] far);
    xform_reg_e idx;
    logic [31:0] vals [4];
    vals = '{ox, oy, oz, far};
    for (int i = 0; i < 4; i++) begin
      idx = xform_reg_e'(i);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.write_reg(idx, vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // load a sane matrix now and then, rotate, move, then look at it
  task automatic transform_burst();
    logic [31:0] v [3];
    if ($urandom_range(0, 99) < 40) begin
      for (int i = 0; i < 12; i++)
        do_write(i, (i == 0 || i == 5 || i == 10) ? UNIT :
                    (i % 4 == 3) ? small_signed(1 << 20) : 32'd0);
    end
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 99) < 60) do_rotate(rand_angle(), rand_angle(), rand_angle());
      else do_rotate_packed(30'($urandom));
    end
    repeat ($urandom_range(1, 3)) begin
      for (int i = 0; i < 3; i++)
        v[i] = ($urandom_range(0, 9) == 0) ? $urandom : small_signed(1 << 16);
      do_move(($urandom_range(0, 99) < 60) ? CMD_TRANSLATE_REL : CMD_TRANSLATE_ABS,
              v[0], v[1], v[2]);
    end
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 1) == 1) do_read(4 * $urandom_range(0, 2) + 3);
      else do_read($urandom_range(0, 11));
    end
  endtask

  task automatic run_random(int n);
    int stop_at;
    stop_at = words_sent + n;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 99) < 65) begin
        transform_burst();
      end else begin
        repeat ($urandom_range(3, 10))
          send_word(xform_cmd_e'($urandom_range(0, 7)), random_fields());
      end
    end
  endtask

  task automatic directed_words();
    xform_fields_t f;
    do_read(0);
    do_read(15);
    do_write(13, 32'hDEAD_BEEF);
    do_read(13);
    do_rotate(16'd0, 16'd0, 16'd0);
    do_rotate(QUARTER_TURN, 16'd0, 16'd0);
    do_rotate(16'h8000, 16'h7FFF, 16'hFFFF);
    do_rotate_packed('1);
    do_rotate_packed('0);
    do_move(CMD_TRANSLATE_REL, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    do_move(CMD_TRANSLATE_REL, 32'd0, 32'd0, 32'd0);
    do_move(CMD_TRANSLATE_ABS, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
    f = '1;
    send_word(CMD_UNUSED_6, f);
    f = '0;
    send_word(CMD_UNUSED_7, f);
    do_read(3);
    do_read(7);
    do_read(11);
    do_write(0, 32'h8000_0000);
    do_write(5, 32'h7FFF_FFFF);
    // most negative translation never counts as in range
    do_write(3, 32'h8000_0000);
    do_move(CMD_TRANSLATE_REL, 32'd0, 32'd0, 32'd0);
    do_read(0);
    do_read(5);
  endtask

  initial begin : result_sink
    int hold;
    hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tuser[0]);
      if (hold_request) begin
        hold_request = 1'b0;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 13);
      end
    end
  end

  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) stalled = 0;
      else stalled++;
    end
    $display("fixed_point_matrix_transform_engine_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    sb            = new();
    no_idle       = 1'b0;
    hold_request  = 1'b0;
    words_sent    = 0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_ORIGIN_X;
    cfg_data_i    = 32'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_WRITE_ENTRY;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 5; ph++) begin
      wait_drained();
      case (ph)
        0: set_regs(32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF);
        1: set_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
        2: set_regs($urandom, $urandom, $urandom, $urandom_range(1 << 29, 1 << 30));
        3: set_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    $urandom_range(1 << 26, 32'h7FFF_FFFF));
        default: set_regs(small_signed(1 << 20), $urandom, small_signed(1 << 20),
                          $urandom_range(1 << 20, 1 << 31));
      endcase
      no_idle = (ph == 2);
      if (ph == 0) directed_words();
      if (ph == 1) hold_request = 1'b1;
      if (ph == 3) begin
        run_random(PHASE_WORDS / 2);
        wait_drained();
        run_random(PHASE_WORDS - PHASE_WORDS / 2);
      end else begin
        run_random(PHASE_WORDS);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) sb.flag($sformatf("%0d words never arrived", sb.pending()));
    if (sb.errors == 0) $display("fixed_point_matrix_transform_engine_tb OK");
    else $display("fixed_point_matrix_transform_engine_tb NOT OK");
    $finish;
  end

endmodule
